>>> hw/rtl/ple_pkg.sv
// Shared constants, codes and item types for the positional list engine.
package ple_pkg;

  localparam int CAPACITY   = 32;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int PTR_W      = IDX_W + 1;

  localparam logic [PTR_W-1:0] NIL = PTR_W'(CAPACITY);

  localparam logic [2:0] K_INS_HEAD = 3'd0;
  localparam logic [2:0] K_INS_TAIL = 3'd1;
  localparam logic [2:0] K_INS_POS  = 3'd2;
  localparam logic [2:0] K_DEL_HEAD = 3'd3;
  localparam logic [2:0] K_DEL_TAIL = 3'd4;
  localparam logic [2:0] K_DEL_POS  = 3'd5;
  localparam logic [2:0] K_READ     = 3'd6;
  localparam logic [2:0] K_CLEAR    = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_POS = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [2:0]         kind;
    logic [5:0]         position;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic               element_valid;
    logic               last;
    logic [5:0]         size;
  } out_item_t;

  typedef struct packed {
    logic                  ins;
    logic                  del;
    logic                  at_head;
    logic                  at_tail;
    logic                  read;
    logic                  clear;
    logic [5:0]            position;
    logic [DATA_WIDTH-1:0] data;
  } req_t;

endpackage

>>> hw/rtl/ple_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ple_ram #(
  parameter int W = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/ple_front.sv
// Front end: accepts items, decodes the request kind and queues requests.
module ple_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  ple_pkg::in_item_t in_item,
  output logic              req_valid,
  output ple_pkg::req_t     req,
  input  logic              req_take
);
  import ple_pkg::*;

  req_t       q_r [2];
  logic       wr_r, wr_nxt, rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  req_t       dec;
  logic       push_ok, take_ok;

  always_comb begin
    dec          = '0;
    dec.ins      = (in_item.kind == K_INS_HEAD) || (in_item.kind == K_INS_TAIL) ||
                   (in_item.kind == K_INS_POS);
    dec.del      = (in_item.kind == K_DEL_HEAD) || (in_item.kind == K_DEL_TAIL) ||
                   (in_item.kind == K_DEL_POS);
    dec.at_head  = (in_item.kind == K_INS_HEAD) || (in_item.kind == K_DEL_HEAD);
    dec.at_tail  = (in_item.kind == K_INS_TAIL) || (in_item.kind == K_DEL_TAIL);
    dec.read     = (in_item.kind == K_READ);
    dec.clear    = (in_item.kind == K_CLEAR);
    dec.position = in_item.position;
    dec.data     = DATA_WIDTH'($unsigned(in_item.value));
  end

  assign in_full   = (cnt_r == 2'd2);
  assign req_valid = (cnt_r != 2'd0);
  assign req       = q_r[rd_r];
  assign push_ok   = in_push && !in_full;
  assign take_ok   = req_take && req_valid;

  always_comb begin
    wr_nxt  = push_ok ? ~wr_r : wr_r;
    rd_nxt  = take_ok ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(push_ok) - 2'(take_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push_ok) begin
      q_r[wr_r] <= dec;
    end
  end

endmodule

>>> hw/rtl/ple_outq.sv
// Two-entry result queue between the back end and the result ports.
module ple_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_push,
  output logic               res_full,
  input  ple_pkg::out_item_t res_item,
  output logic               out_empty,
  input  logic               out_pop,
  output ple_pkg::out_item_t out_item
);
  import ple_pkg::*;

  out_item_t  q_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;
  logic       push_ok, pop_ok;

  assign res_full  = (cnt_r == 2'd2);
  assign out_empty = (cnt_r == 2'd0);
  assign out_item  = q_r[rd_r];
  assign push_ok   = res_push && !res_full;
  assign pop_ok    = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok) wr_r <= ~wr_r;
      if (pop_ok) rd_r <= ~rd_r;
      cnt_r <= cnt_r + 2'(push_ok) - 2'(pop_ok);
    end
    if (push_ok) begin
      q_r[wr_r] <= res_item;
    end
  end

endmodule

>>> hw/rtl/ple_back.sv
// Back end: sequencer that walks and relinks the node memories.
module ple_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_valid,
  input  ple_pkg::req_t      req,
  output logic               req_take,
  output logic               res_push,
  output ple_pkg::out_item_t res_item,
  input  logic               res_full
);
  import ple_pkg::*;

  localparam int CW = ((PTR_W > 6) ? PTR_W : 6) + 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_WALK   = 4'd1;
  localparam logic [3:0] S_WSTEP  = 4'd2;
  localparam logic [3:0] S_LUSE   = 4'd3;
  localparam logic [3:0] S_LINK1  = 4'd4;
  localparam logic [3:0] S_LINK2  = 4'd5;
  localparam logic [3:0] S_UNLINK = 4'd6;
  localparam logic [3:0] S_RRD    = 4'd7;
  localparam logic [3:0] S_RPUSH  = 4'd8;
  localparam logic [3:0] S_RESP   = 4'd9;

  logic [3:0]       state_r, state_nxt;
  req_t             cur_r, cur_nxt;
  logic [PTR_W-1:0] n_r, n_nxt, p_r, p_nxt, q_r, q_nxt, m_r, m_nxt;
  logic [PTR_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [PTR_W-1:0] count_r, count_nxt, hwm_r, hwm_nxt, fcnt_r, fcnt_nxt;
  logic [5:0]       steps_r, steps_nxt;
  logic [1:0]       st_r, st_nxt;

  logic                  val_we, nxt_we, prv_we, stk_we;
  logic [IDX_W-1:0]      val_wa, nxt_wa, prv_wa, stk_wa;
  logic [DATA_WIDTH-1:0] val_wd, val_rd;
  logic [PTR_W-1:0]      nxt_wd, nxt_rd, prv_wd, prv_rd;
  logic [IDX_W-1:0]      stk_wd, stk_rd;
  logic [CW-1:0]         pos_w, cnt_w;
  logic [PTR_W-1:0]      alloc;

  ple_ram #(.W(DATA_WIDTH), .DEPTH(CAPACITY)) u_val (
    .clk, .we(val_we), .waddr(val_wa), .wdata(val_wd),
    .raddr(n_r[IDX_W-1:0]), .rdata(val_rd));
  ple_ram #(.W(PTR_W), .DEPTH(CAPACITY)) u_nxt (
    .clk, .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
    .raddr(n_r[IDX_W-1:0]), .rdata(nxt_rd));
  ple_ram #(.W(PTR_W), .DEPTH(CAPACITY)) u_prv (
    .clk, .we(prv_we), .waddr(prv_wa), .wdata(prv_wd),
    .raddr(n_r[IDX_W-1:0]), .rdata(prv_rd));
  // Stack of released nodes; its read port is addressed at the top entry, with registered read data.
  ple_ram #(.W(IDX_W), .DEPTH(CAPACITY)) u_stk (
    .clk, .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
    .raddr(IDX_W'(fcnt_r - PTR_W'(1))), .rdata(stk_rd));

  assign pos_w = CW'(req.position);
  assign cnt_w = CW'(count_r);
  // Released nodes are reused first; otherwise a never-used node is taken.
  assign alloc = (fcnt_r != '0) ? PTR_W'(stk_rd) : hwm_r;

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    n_nxt     = n_r;
    p_nxt     = p_r;
    q_nxt     = q_r;
    m_nxt     = m_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    hwm_nxt   = hwm_r;
    fcnt_nxt  = fcnt_r;
    steps_nxt = steps_r;
    st_nxt    = st_r;
    req_take  = 1'b0;
    res_push  = 1'b0;
    res_item  = '0;
    val_we    = 1'b0;
    val_wa    = m_r[IDX_W-1:0];
    val_wd    = cur_r.data;
    nxt_we    = 1'b0;
    nxt_wa    = alloc[IDX_W-1:0];
    nxt_wd    = q_r;
    prv_we    = 1'b0;
    prv_wa    = alloc[IDX_W-1:0];
    prv_wd    = p_r;
    stk_we    = 1'b0;
    stk_wa    = fcnt_r[IDX_W-1:0];
    stk_wd    = n_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          req_take  = 1'b1;
          cur_nxt   = req;
          st_nxt    = ST_OK;
          n_nxt     = head_r;
          steps_nxt = req.position - 6'd1;
          state_nxt = S_RESP;
          if (req.ins) begin
            if (count_r == PTR_W'(CAPACITY)) begin
              st_nxt = ST_FULL;
            end else if (!req.at_head && !req.at_tail &&
                         (pos_w == '0 || pos_w > cnt_w + CW'(1))) begin
              st_nxt = ST_BAD_POS;
            end else if (req.at_head || (!req.at_tail && pos_w == CW'(1))) begin
              p_nxt     = NIL;
              q_nxt     = head_r;
              state_nxt = S_LINK1;
            end else if (req.at_tail || pos_w == cnt_w + CW'(1)) begin
              p_nxt     = tail_r;
              q_nxt     = NIL;
              state_nxt = S_LINK1;
            end else begin
              state_nxt = S_WALK;
            end
          end else if (req.del) begin
            if (req.at_head || req.at_tail) begin
              if (count_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                n_nxt     = req.at_head ? head_r : tail_r;
                steps_nxt = '0;
                state_nxt = S_WALK;
              end
            end else if (pos_w == '0 || pos_w > cnt_w) begin
              st_nxt = ST_BAD_POS;
            end else begin
              state_nxt = S_WALK;
            end
          end else if (req.read) begin
            if (count_r != '0) state_nxt = S_RRD;
          end else begin
            head_nxt  = NIL;
            tail_nxt  = NIL;
            count_nxt = '0;
            hwm_nxt   = '0;
            fcnt_nxt  = '0;
          end
        end
      end
      S_WALK: begin
        // The link read of the current node is under way in this cycle.
        state_nxt = (steps_r == '0) ? S_LUSE : S_WSTEP;
      end
      S_WSTEP: begin
        n_nxt     = nxt_rd;
        steps_nxt = steps_r - 6'd1;
        state_nxt = S_WALK;
      end
      S_LUSE: begin
        p_nxt = prv_rd;
        if (cur_r.ins) begin
          q_nxt     = n_r;
          state_nxt = S_LINK1;
        end else begin
          q_nxt     = nxt_rd;
          state_nxt = S_UNLINK;
        end
      end
      S_LINK1: begin
        m_nxt  = alloc;
        val_we = 1'b1;
        val_wa = alloc[IDX_W-1:0];
        nxt_we = 1'b1;
        prv_we = 1'b1;
        if (fcnt_r != '0) fcnt_nxt = fcnt_r - PTR_W'(1);
        else hwm_nxt = hwm_r + PTR_W'(1);
        state_nxt = S_LINK2;
      end
      S_LINK2: begin
        nxt_wa = p_r[IDX_W-1:0];
        nxt_wd = m_r;
        prv_wa = q_r[IDX_W-1:0];
        prv_wd = m_r;
        if (p_r != NIL) nxt_we = 1'b1;
        else head_nxt = m_r;
        if (q_r != NIL) prv_we = 1'b1;
        else tail_nxt = m_r;
        count_nxt = count_r + PTR_W'(1);
        state_nxt = S_RESP;
      end
      S_UNLINK: begin
        nxt_wa = p_r[IDX_W-1:0];
        nxt_wd = q_r;
        prv_wa = q_r[IDX_W-1:0];
        prv_wd = p_r;
        if (p_r != NIL) nxt_we = 1'b1;
        else head_nxt = q_r;
        if (q_r != NIL) prv_we = 1'b1;
        else tail_nxt = p_r;
        stk_we    = 1'b1;
        fcnt_nxt  = fcnt_r + PTR_W'(1);
        count_nxt = count_r - PTR_W'(1);
        state_nxt = S_RESP;
      end
      S_RRD: begin
        state_nxt = S_RPUSH;
      end
      S_RPUSH: begin
        // n_r holds while stalled, so the read data stays put.
        res_item.status        = ST_OK;
        res_item.element       = 32'(val_rd);
        res_item.element_valid = 1'b1;
        res_item.last          = (nxt_rd == NIL);
        res_item.size          = 6'(count_r);
        if (!res_full) begin
          res_push  = 1'b1;
          n_nxt     = nxt_rd;
          state_nxt = (nxt_rd == NIL) ? S_IDLE : S_RRD;
        end
      end
      S_RESP: begin
        res_item.status = st_r;
        res_item.last   = 1'b1;
        res_item.size   = 6'(count_r);
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= NIL;
      tail_r  <= NIL;
      count_r <= '0;
      hwm_r   <= '0;
      fcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      hwm_r   <= hwm_nxt;
      fcnt_r  <= fcnt_nxt;
    end
    cur_r   <= cur_nxt;
    n_r     <= n_nxt;
    p_r     <= p_nxt;
    q_r     <= q_nxt;
    m_r     <= m_nxt;
    steps_r <= steps_nxt;
    st_r    <= st_nxt;
  end

endmodule

>>> hw/rtl/positional_list_engine.sv
// Top level of the positional list engine: front end, sequencer and result queue.
//
//   channel  | ports                        | moves
//   ---------+------------------------------+--------------------------------
//   input    | in_push, in_full, in_item    | one request item
//   result   | out_pop, out_empty, out_item | one result item
//
// An end insert runs the sequencer states LINK1 and LINK2 and an end delete WALK, LUSE
// and UNLINK; a positional request adds WALK and WSTEP per link followed, since each
// step waits on a registered read of the next-link memory. Read out runs RRD and RPUSH
// per element. Reset clears the list at once: nodes are handed out by a high-water
// count and a stack of released nodes, so no clearing pass is needed. Either side may
// stall freely; two-entry queues sit at the input and at the result side.
module positional_list_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  ple_pkg::in_item_t  in_item,
  input  logic               out_pop,
  output logic               out_empty,
  output ple_pkg::out_item_t out_item
);
  import ple_pkg::*;

  logic      req_valid, req_take, res_push, res_full;
  req_t      req;
  out_item_t res_item;

  ple_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_item,
    .req_valid, .req, .req_take);

  ple_back u_back (
    .clk, .rst_n, .req_valid, .req, .req_take,
    .res_push, .res_item, .res_full);

  ple_outq u_outq (
    .clk, .rst_n, .res_push, .res_full, .res_item,
    .out_empty, .out_pop, .out_item);

endmodule
